[sv/hlt_pkg.sv]
// Shared types and codes for the heartbeat liveness table.
package hlt_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_BEAT = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  localparam logic [7:0] MISSED_MAX = 8'd255;
  localparam logic [7:0] THRESHOLD_RESET = 8'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] peer_id;
  } in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] alive_peer;
    logic        last;
    logic        leader_valid;
    logic [31:0] leader;
    logic [4:0]  alive_count;
    logic        table_full;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_LIST
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;        // apply tick / heartbeat from the input transfer
    logic sweep_step;  // examine the slot at the pointer, evict if dead
    logic ptr_clr;
    logic emit_single;
    logic emit_list;   // emit slot at the pointer and advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;      // pointer has reached the entry count
    logic is_list;
    logic empty;
    logic list_last;
  } sts_t;

endpackage

[sv/heartbeat_liveness_table.sv]
// Top level of the heartbeat liveness table: controller plus datapath.
//
// Keeps up to TABLE_DEPTH peer ids in ascending order with a missed-tick count each.
// An item is taken when start is high and busy is low. The operation is applied in
// the cycle of the transfer, then an eviction sweep walks the occupied slots, one
// slot per cycle, the pointer held on an eviction; busy drops after the sweep, or
// after a listing's last peer. Results come out of a register the cycle after
// they are formed, each shown for exactly one cycle with out_valid high and no way
// to hold them off. The threshold port is always ready; write it while idle.
module heartbeat_liveness_table import hlt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hlt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  hlt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sv/hlt_ctrl.sv]
// Sequencer for the heartbeat liveness table: operation, eviction sweep, listing.
module hlt_ctrl import hlt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!sts.at_end) begin
          cmd.sweep_step = 1'b1;
        end else if (sts.is_list && !sts.empty) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = ST_LIST;
        end else begin
          cmd.emit_single = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_LIST: begin
        cmd.emit_list = 1'b1;
        if (sts.list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/hlt_dp.sv]
// Datapath: sorted peer table, missed counters, threshold and result register.
module hlt_dp import hlt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_t        in_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  output out_t       out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [31:0]   peer_r [TABLE_DEPTH];
  logic [31:0]   peer_nxt [TABLE_DEPTH];
  logic [7:0]    miss_r [TABLE_DEPTH];
  logic [7:0]    miss_nxt [TABLE_DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    op_r, op_nxt;
  logic          full_r, full_nxt;
  logic [7:0]    thr_r;
  logic          out_valid_r;
  out_t          out_r, out_nxt;

  logic [TABLE_DEPTH-1:0] lt, eq, dead, ins;
  logic [TABLE_DEPTH:0]   ltx;
  logic                   hit;
  logic [IW-1:0]          idx;

  assign idx = ptr_r[IW-1:0];
  assign hit = |eq;
  assign ltx = {lt, 1'b1};

  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      lt[k]   = (CW'(k) < count_r) && (peer_r[k] < in_data.peer_id);
      eq[k]   = (CW'(k) < count_r) && (peer_r[k] == in_data.peer_id);
      dead[k] = miss_r[k] >= thr_r;
      ins[k]  = !lt[k] && ltx[k];
    end
  end

  assign sts.at_end    = (ptr_r == count_r);
  assign sts.is_list   = (op_r == OP_LIST);
  assign sts.empty     = (count_r == '0);
  assign sts.list_last = ((ptr_r + CW'(1)) == count_r);

  always_comb begin
    peer_nxt  = peer_r;
    miss_nxt  = miss_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    op_nxt    = op_r;
    full_nxt  = full_r;
    out_nxt   = out_r;

    if (cmd.exec) begin
      op_nxt   = in_data.operation;
      ptr_nxt  = '0;
      full_nxt = 1'b0;
      case (in_data.operation)
        OP_TICK: begin
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (miss_r[k] != MISSED_MAX) begin
              miss_nxt[k] = miss_r[k] + 8'd1;
            end
          end
        end
        OP_BEAT: begin
          if (hit) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
              if (eq[k]) begin
                miss_nxt[k] = '0;
              end
            end
          end else if (count_r == DEPTH_C) begin
            full_nxt = 1'b1;
          end else begin
            // sorted insert: slots below the position keep, the rest move up
            if (ins[0]) begin
              peer_nxt[0] = in_data.peer_id;
              miss_nxt[0] = '0;
            end
            for (int k = 1; k < TABLE_DEPTH; k++) begin
              if (ins[k]) begin
                peer_nxt[k] = in_data.peer_id;
                miss_nxt[k] = '0;
              end else if (!lt[k]) begin
                peer_nxt[k] = peer_r[k-1];
                miss_nxt[k] = miss_r[k-1];
              end
            end
            count_nxt = count_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.sweep_step) begin
      if (dead[idx]) begin
        // close the gap; pointer stays to look at the slot that moved in
        for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
          if (CW'(k) >= ptr_r) begin
            peer_nxt[k] = peer_r[k+1];
            miss_nxt[k] = miss_r[k+1];
          end
        end
        count_nxt = count_r - CW'(1);
      end else begin
        ptr_nxt = ptr_r + CW'(1);
      end
    end

    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end

    out_nxt.leader_valid = (count_r != '0);
    out_nxt.leader       = (count_r != '0) ? peer_r[0] : 32'd0;
    out_nxt.alive_count  = 5'(count_r);

    if (cmd.emit_single) begin
      out_nxt.entry_valid = 1'b0;
      out_nxt.alive_peer  = 32'd0;
      out_nxt.last        = 1'b1;
      out_nxt.table_full  = full_r;
    end else if (cmd.emit_list) begin
      out_nxt.entry_valid = 1'b1;
      out_nxt.alive_peer  = peer_r[idx];
      out_nxt.last        = sts.list_last;
      out_nxt.table_full  = 1'b0;
      ptr_nxt             = ptr_r + CW'(1);
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit_single | cmd.emit_list;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    peer_r <= peer_nxt;
    miss_r <= miss_nxt;
    ptr_r  <= ptr_nxt;
    op_r   <= op_nxt;
    full_r <= full_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
